// ===== rtl/core/periodic_down_count_timer_macros.svh =====
// Assertion macros for the periodic down-count timer.
// Used by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef PERIODIC_DOWN_COUNT_TIMER_MACROS_SVH
`define PERIODIC_DOWN_COUNT_TIMER_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked on every rising edge and held off while reset is asserted.
`define PTMR_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("periodic_down_count_timer assertion failed");
// Checked on every rising edge, including during reset.
`define PTMR_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("periodic_down_count_timer assertion failed");
`else
`define PTMR_ASSERT(label, clk, rst_n, prop)
`define PTMR_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== rtl/core/ptmr_pkg.sv =====
// Shared types and constants for the periodic down-count timer.
// No dependencies; used by every module of the block.
package ptmr_pkg;

  typedef enum logic [1:0] {
    FuncTick  = 2'd0,
    FuncRead  = 2'd1,
    FuncWrite = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    StatusOk         = 2'd0,
    StatusBadOffset  = 2'd1,
    StatusOutOfRange = 2'd2
  } status_e;

  // Register offsets inside the four-register window.
  localparam logic [3:0] OfsCfg      = 4'h0;
  localparam logic [3:0] OfsPeriod   = 4'h4;
  localparam logic [3:0] OfsCount    = 4'h8;
  localparam logic [3:0] OfsPrescale = 4'hC;

  localparam int unsigned BitEnable = 0;
  localparam int unsigned BitIntEn  = 1;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] address;
    logic [31:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [1:0]  status;
    logic        irq;
  } out_item_t;

endpackage

// ===== rtl/core/ptmr_in_stage.sv =====
// Input register of the timer: holds one accepted transfer until the core takes it.
// Depends on ptmr_pkg for the input item type.
module ptmr_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ptmr_pkg::in_item_t in_item_i,
  input  logic               down_ready_i,
  output logic               item_valid_o,
  output ptmr_pkg::in_item_t item_o
);

  logic               valid_q, valid_d;
  ptmr_pkg::in_item_t item_q;
  logic               accept;

  // The held item leaves whenever the result register can take its result.
  assign in_stall_o = valid_q && !down_ready_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign valid_d    = accept ? 1'b1 : (down_ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// ===== rtl/core/ptmr_core.sv =====
// Timer registers, prescaler and bus decode; computes one result per item.
// Depends on ptmr_pkg and periodic_down_count_timer_macros.svh.
`include "periodic_down_count_timer_macros.svh"

module ptmr_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic                fire_i,
  input  ptmr_pkg::in_item_t  item_i,
  output ptmr_pkg::out_item_t result_o
);

  logic [31:0] base_q;
  logic [31:0] ctrl_q, ctrl_d;
  logic [31:0] period_q, period_d;
  logic [31:0] count_q, count_d;
  logic [31:0] prescale_q, prescale_d;
  logic        pending_q, pending_d;
  logic [31:0] remain_q, remain_d;

  logic [31:0] offset;
  logic        in_window;
  logic [31:0] remain_dec;
  logic [31:0] count_dec;
  logic [31:0] arm_value;
  ptmr_pkg::out_item_t res;
  logic        res_err;
  logic        count_wr;

  assign offset     = item_i.address - base_q;
  assign in_window  = (offset[31:4] == 28'd0);
  assign remain_dec = remain_q - 32'd1;
  assign count_dec  = count_q - 32'd1;
  assign arm_value  = (prescale_q == 32'd0) ? 32'd1 : prescale_q;

  always_comb begin
    ctrl_d     = ctrl_q;
    period_d   = period_q;
    count_d    = count_q;
    prescale_d = prescale_q;
    pending_d  = pending_q;
    remain_d   = remain_q;
    res        = '0;
    res.status = ptmr_pkg::StatusOk;

    if (item_i.func == ptmr_pkg::FuncTick) begin
      if (pending_q) begin
        remain_d = remain_dec;
        if (remain_dec == 32'd0) begin
          pending_d = 1'b0;
          if (ctrl_q[ptmr_pkg::BitEnable]) begin
            // Count wraps below zero; reaching zero reloads the period, and every expiry re-arms.
            if (count_dec == 32'd0) begin
              count_d = period_q;
              res.irq = ctrl_q[ptmr_pkg::BitIntEn];
            end else begin
              count_d = count_dec;
            end
            pending_d = 1'b1;
            remain_d  = arm_value;
          end
        end
      end
    end else if (item_i.func == ptmr_pkg::FuncRead ||
                 item_i.func == ptmr_pkg::FuncWrite) begin
      if (!in_window) begin
        res.status = ptmr_pkg::StatusOutOfRange;
      end else if (item_i.func == ptmr_pkg::FuncRead) begin
        case (offset[3:0])
          ptmr_pkg::OfsCfg:      res.read_data = ctrl_q;
          ptmr_pkg::OfsPeriod:   res.read_data = period_q;
          ptmr_pkg::OfsCount:    res.read_data = count_q;
          ptmr_pkg::OfsPrescale: res.read_data = prescale_q;
          default:               res.status    = ptmr_pkg::StatusBadOffset;
        endcase
      end else begin
        case (offset[3:0])
          ptmr_pkg::OfsCfg: begin
            // Enabling drops any pending event and arms a fresh one.
            if (item_i.write_data[ptmr_pkg::BitEnable]) begin
              pending_d = 1'b1;
              remain_d  = arm_value;
            end
            ctrl_d = item_i.write_data;
          end
          ptmr_pkg::OfsPeriod:   period_d   = item_i.write_data;
          ptmr_pkg::OfsCount:    count_d    = item_i.write_data;
          ptmr_pkg::OfsPrescale: prescale_d = item_i.write_data;
          default:               res.status = ptmr_pkg::StatusBadOffset;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q     <= '0;
      ctrl_q     <= '0;
      period_q   <= '0;
      count_q    <= '0;
      prescale_q <= '0;
      pending_q  <= 1'b0;
      remain_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
      if (fire_i) begin
        ctrl_q     <= ctrl_d;
        period_q   <= period_d;
        count_q    <= count_d;
        prescale_q <= prescale_d;
        pending_q  <= pending_d;
        remain_q   <= remain_d;
      end
    end
  end

  assign result_o = res;

  assign res_err  = (res.status != ptmr_pkg::StatusOk);
  assign count_wr = fire_i && item_i.func == ptmr_pkg::FuncWrite && in_window &&
                    offset[3:0] == ptmr_pkg::OfsCount;

  `PTMR_ASSERT(a_pending_has_ticks, clk_i, rst_ni, pending_q |-> remain_q != 32'd0)
  `PTMR_ASSERT(a_irq_only_on_tick, clk_i, rst_ni, res.irq |-> item_i.func == ptmr_pkg::FuncTick)
  `PTMR_ASSERT(a_error_reads_zero, clk_i, rst_ni, res_err |-> res.read_data == 32'd0)
  `PTMR_ASSERT(a_count_write_lands, clk_i, rst_ni, count_wr |=> count_q == $past(item_i.write_data))
  `PTMR_ASSERT(a_idle_holds_count, clk_i, rst_ni, !fire_i && !cfg_we_i |=> $stable(count_q))

endmodule

// ===== rtl/core/ptmr_out_stage.sv =====
// Result register of the timer: holds one result transfer until the consumer takes it.
// Depends on ptmr_pkg for the result item type.
module ptmr_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                up_valid_i,
  output logic                up_ready_o,
  input  ptmr_pkg::out_item_t result_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ptmr_pkg::out_item_t out_item_o
);

  logic                valid_q, valid_d;
  ptmr_pkg::out_item_t item_q;
  logic                load;

  assign up_ready_o = !valid_q || !out_stall_i;
  assign load       = up_valid_i && up_ready_o;
  assign valid_d    = load ? 1'b1 : (out_stall_i ? valid_q : 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

// ===== rtl/core/periodic_down_count_timer.sv =====
// Periodic down-count timer with tick prescaler on a four-register bus window.
// A result passes through the input register and then the result register; a stall can hold either.
// Throughput: one item per cycle while the output is not stalled; the core updates all timer state in one pass.
// Reset clears all timer registers, the base address and the armed-event state at once.
// Built from ptmr_in_stage, ptmr_core and ptmr_out_stage; types from ptmr_pkg.
module periodic_down_count_timer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ptmr_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ptmr_pkg::out_item_t out_item_o
);

  logic                item_valid;
  ptmr_pkg::in_item_t  item;
  logic                down_ready;
  logic                fire;
  ptmr_pkg::out_item_t result;

  assign fire = item_valid && down_ready;

  ptmr_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item_i),
    .down_ready_i (down_ready),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  ptmr_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .item_i      (item),
    .result_o    (result)
  );

  ptmr_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .up_valid_i  (item_valid),
    .up_ready_o  (down_ready),
    .result_i    (result),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
